// File: rtl/core/ubx_survey_frame_receiver_macros.svh
// assertion macros for the base-station frame receiver
// expects clk and rst_n in the scope where a macro is used
`ifndef UBX_SURVEY_FRAME_RECEIVER_MACROS_SVH
`define UBX_SURVEY_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, held off while in reset
`define UBXSV_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while in reset
`define UBXSV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ubxsv_pkg.sv
// shared types and constants of the base-station frame receiver
// no dependencies
`timescale 1ns / 1ps

package ubxsv_pkg;

    localparam int FRAME_LIMIT = 512;
    localparam int COUNT_W     = $clog2(FRAME_LIMIT + 1);

    localparam logic [7:0]  SYNC_A      = 8'hB5;
    localparam logic [7:0]  SYNC_B      = 8'h62;
    localparam logic [7:0]  CLS_CFG     = 8'h06;
    localparam logic [7:0]  ID_TMODE3   = 8'h71;
    localparam logic [7:0]  CLS_NAV     = 8'h01;
    localparam logic [7:0]  ID_SVIN     = 8'h3B;
    localparam logic [15:0] MIN_PAYLOAD = 16'd40;
    localparam logic [15:0] HDR_LEN     = 16'd8;

    localparam logic [31:0] SURVEY_MIN_RESET = 32'd20;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_SURVEY = 2'd1,
        MODE_FIXED  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        REQ_NONE   = 2'd0,
        REQ_SURVEY = 2'd1,
        REQ_FIXED  = 2'd2
    } req_t;

    // per-item result that is not stored state
    typedef struct packed {
        logic  fwd;
        logic  done;
        req_t  req;
    } step_t;

    // stored survey results
    typedef struct packed {
        logic        [31:0] duration;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic        [31:0] accuracy;
        logic               valid;
        logic               active;
    } survey_t;

endpackage

// File: rtl/core/ubxsv_parser.sv
// frame parser and base-mode state: one byte per accepted item
// depends on ubxsv_pkg
`timescale 1ns / 1ps

module ubxsv_parser
    import ubxsv_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    rx_byte,
    input  logic [31:0]   survey_min_duration,
    output step_t         step,
    output mode_t         mode,
    output survey_t       survey
);

    typedef enum logic [1:0] {
        PH_SYNC1 = 2'd0,
        PH_SYNC2 = 2'd1,
        PH_BODY  = 2'd2
    } phase_t;

    // payload offsets of duration, x, y, z, accuracy (element 0 is duration)
    localparam logic [4:0][5:0] WORD_OFS = {6'd28, 6'd20, 6'd16, 6'd12, 6'd8};
    localparam int MODE_OFS     = 2;
    localparam int VALID_OFS    = 36;
    localparam int ACTIVE_OFS   = 37;

    mode_t               mode_reg, mode_next;
    phase_t              phase_reg, phase_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [15:0]         len_reg, len_next;
    logic [7:0]          class_reg, class_next;
    logic [7:0]          ident_reg, ident_next;
    logic [7:0]          mode_byte_reg, mode_byte_next;
    logic [31:0]         cap_words_reg [5];
    logic [31:0]         cap_words_next [5];
    logic [7:0]          cap_flags_reg [2];
    logic [7:0]          cap_flags_next [2];
    logic [31:0]         kept_words_reg [5];
    logic [31:0]         kept_words_next [5];
    logic [1:0]          kept_flags_reg, kept_flags_next;

    logic [COUNT_W-1:0]  count_inc;
    logic [COUNT_W-1:0]  offset;
    logic [15:0]         frame_len;
    step_t               step_c;

    always_comb
    begin
        mode_next       = mode_reg;
        phase_next      = phase_reg;
        count_next      = count_reg;
        len_next        = len_reg;
        class_next      = class_reg;
        ident_next      = ident_reg;
        mode_byte_next  = mode_byte_reg;
        cap_words_next  = cap_words_reg;
        cap_flags_next  = cap_flags_reg;
        kept_words_next = kept_words_reg;
        kept_flags_next = kept_flags_reg;
        step_c          = '{fwd: 1'b0, done: 1'b0, req: REQ_NONE};
        count_inc       = count_reg + COUNT_W'(1);
        offset          = count_reg - COUNT_W'(6);
        frame_len       = '0;

        if (mode_reg == MODE_FIXED)
        begin
            // parser frozen, bytes pass on as correction data
            step_c.fwd = 1'b1;
        end
        else
        begin
            unique case (phase_reg)
                PH_SYNC1:
                begin
                    if (rx_byte == SYNC_A)
                    begin
                        count_next = COUNT_W'(1);
                        phase_next = PH_SYNC2;
                    end
                end
                PH_SYNC2:
                begin
                    if (rx_byte == SYNC_B)
                    begin
                        count_next = COUNT_W'(2);
                        phase_next = PH_BODY;
                    end
                    else
                    begin
                        count_next = '0;
                        phase_next = PH_SYNC1;
                    end
                end
                PH_BODY:
                begin
                    priority if (count_reg == COUNT_W'(2))
                        class_next = rx_byte;
                    else if (count_reg == COUNT_W'(3))
                        ident_next = rx_byte;
                    else if (count_reg == COUNT_W'(4))
                        len_next[7:0] = rx_byte;
                    else if (count_reg == COUNT_W'(5))
                        len_next[15:8] = rx_byte;
                    else
                    begin
                        // capture the payload bytes we care about on the fly
                        if (offset == COUNT_W'(MODE_OFS))
                            mode_byte_next = rx_byte;
                        for (int w = 0; w < 5; w++)
                            for (int k = 0; k < 4; k++)
                                if (offset == COUNT_W'(WORD_OFS[w] + k))
                                    cap_words_next[w][8*k +: 8] = rx_byte;
                        if (offset == COUNT_W'(VALID_OFS))
                            cap_flags_next[0] = rx_byte;
                        if (offset == COUNT_W'(ACTIVE_OFS))
                            cap_flags_next[1] = rx_byte;
                    end

                    count_next = count_inc;
                    frame_len  = len_next + HDR_LEN;

                    if (count_inc >= COUNT_W'(8) && 16'(count_inc) == frame_len)
                    begin
                        step_c.done = 1'b1;
                        phase_next  = PH_SYNC1;
                        count_next  = '0;
                        if (len_next >= MIN_PAYLOAD)
                        begin
                            if (class_next == CLS_CFG && ident_next == ID_TMODE3)
                            begin
                                if (mode_byte_next == 8'd1)
                                    mode_next = MODE_SURVEY;
                                else if (mode_byte_next == 8'd2)
                                    mode_next = MODE_FIXED;
                                else
                                begin
                                    step_c.req = REQ_SURVEY;
                                    mode_next  = MODE_SURVEY;
                                end
                            end
                            else if (class_next == CLS_NAV && ident_next == ID_SVIN)
                            begin
                                kept_words_next    = cap_words_next;
                                kept_flags_next[0] = |cap_flags_next[0];
                                kept_flags_next[1] = |cap_flags_next[1];
                                if (kept_flags_next[0] && !kept_flags_next[1]
                                    && cap_words_next[0] >= survey_min_duration)
                                begin
                                    step_c.req = REQ_FIXED;
                                    mode_next  = MODE_FIXED;
                                end
                            end
                        end
                    end
                    else if (count_inc >= COUNT_W'(FRAME_LIMIT))
                    begin
                        // oversize frame, drop it
                        phase_next = PH_SYNC1;
                        count_next = '0;
                    end
                end
                default:
                begin
                    phase_next = PH_SYNC1;
                    count_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            phase_reg      <= PH_SYNC1;
            count_reg      <= '0;
            len_reg        <= '0;
            class_reg      <= '0;
            ident_reg      <= '0;
            mode_byte_reg  <= '0;
            cap_words_reg  <= '{default: '0};
            cap_flags_reg  <= '{default: '0};
            kept_words_reg <= '{default: '0};
            kept_flags_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            len_reg        <= len_next;
            class_reg      <= class_next;
            ident_reg      <= ident_next;
            mode_byte_reg  <= mode_byte_next;
            cap_words_reg  <= cap_words_next;
            cap_flags_reg  <= cap_flags_next;
            kept_words_reg <= kept_words_next;
            kept_flags_reg <= kept_flags_next;
        end
    end

    assign step            = step_c;
    assign mode            = mode_reg;
    assign survey.duration = kept_words_reg[0];
    assign survey.x        = kept_words_reg[1];
    assign survey.y        = kept_words_reg[2];
    assign survey.z        = kept_words_reg[3];
    assign survey.accuracy = kept_words_reg[4];
    assign survey.valid    = kept_flags_reg[0];
    assign survey.active   = kept_flags_reg[1];

endmodule

// File: rtl/core/ubx_survey_frame_receiver.sv
// top level of the base-station frame receiver: handshake, result register, config
// depends on ubxsv_pkg, ubxsv_parser and ubx_survey_frame_receiver_macros.svh
`timescale 1ns / 1ps

// Takes one receiver byte per item and returns one result per item, in the cycle
// after the byte is accepted. A byte can be accepted every cycle: in_ready is
// high whenever the result register is empty or its item is being taken, so a
// sustained rate of one byte per clock holds as long as out_ready stays high.
// The parser and the stored survey values update at the accepting edge; the
// stored fields and base_mode are shown from that state alongside the held
// per-byte flags. survey_min_duration resets to 20 and is written by cfg_wr_en.

module ubx_survey_frame_receiver
    import ubxsv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               forward_valid,
    output logic               frame_done,
    output logic [1:0]         base_mode,
    output logic [1:0]         config_request,
    output logic signed [31:0] mean_x,
    output logic signed [31:0] mean_y,
    output logic signed [31:0] mean_z,
    output logic [31:0]        mean_accuracy,
    output logic [31:0]        survey_seconds,
    output logic               survey_valid,
    output logic               survey_active
);

`include "ubx_survey_frame_receiver_macros.svh"

    logic        out_valid_reg, out_valid_next;
    step_t       step_reg;
    logic [31:0] min_dur_reg;
    logic        accept;
    step_t       step;
    mode_t       mode;
    survey_t     survey;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    ubxsv_parser u_parser (
        .clk                 (clk),
        .rst_n               (rst_n),
        .accept              (accept),
        .rx_byte             (rx_byte),
        .survey_min_duration (min_dur_reg),
        .step                (step),
        .mode                (mode),
        .survey              (survey)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            min_dur_reg   <= SURVEY_MIN_RESET;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                min_dur_reg <= cfg_wr_data;
        end
    end

    // payload register, loaded with the item
    always_ff @(posedge clk)
    begin
        if (accept)
            step_reg <= step;
    end

    assign out_valid      = out_valid_reg;
    assign forward_valid  = step_reg.fwd;
    assign frame_done     = step_reg.done;
    assign config_request = 2'(step_reg.req);
    assign base_mode      = 2'(mode);
    assign mean_x         = survey.x;
    assign mean_y         = survey.y;
    assign mean_z         = survey.z;
    assign mean_accuracy  = survey.accuracy;
    assign survey_seconds = survey.duration;
    assign survey_valid   = survey.valid;
    assign survey_active  = survey.active;

    `UBXSV_ASSERT_IMPL(a_fwd_only_fixed, out_valid_reg && step_reg.fwd, mode == MODE_FIXED, "forwarded byte outside fixed mode")
    `UBXSV_ASSERT_IMPL(a_fwd_no_frame, out_valid_reg && step_reg.fwd, !step_reg.done, "forwarded byte also completed a frame")
    `UBXSV_ASSERT_IMPL(a_req_needs_frame, out_valid_reg && step_reg.req != REQ_NONE, step_reg.done, "config request without a completed frame")
    `UBXSV_ASSERT_IMPL(a_fixed_req_mode, out_valid_reg && step_reg.req == REQ_FIXED, mode == MODE_FIXED, "fixed request without fixed mode")
    `UBXSV_ASSERT_NEXT(a_fixed_sticky, mode == MODE_FIXED, mode == MODE_FIXED, "left fixed mode")

endmodule

// File: dv/testbench.sv
// self-checking bench for the ubx survey frame receiver: sends receiver bytes, predicts
// each per-byte result from its own copy of the parser state and compares field by field
// depends on ubxsv_pkg and the ubx_survey_frame_receiver rtl
`timescale 1ns / 1ps

module testbench;
    import ubxsv_pkg::*;

    // mode byte values carried in a tmode3 reply
    localparam logic [7:0] TM3_SURVEY_IN = 8'd1;
    localparam logic [7:0] TM3_FIXED     = 8'd2;

    typedef enum logic [1:0] {HUNT_SYNC_A, HUNT_SYNC_B, IN_FRAME} hunt_t;
    typedef logic [7:0] byte_q_t[$];

    typedef struct {
        step_t   step;
        mode_t   mode;
        survey_t svy;
    } rx_result_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [31:0]        cfg_wr_data = '0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic [7:0]         rx_byte     = '0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic               forward_valid;
    logic               frame_done;
    logic [1:0]         base_mode;
    logic [1:0]         config_request;
    logic signed [31:0] mean_x;
    logic signed [31:0] mean_y;
    logic signed [31:0] mean_z;
    logic [31:0]        mean_accuracy;
    logic [31:0]        survey_seconds;
    logic               survey_valid;
    logic               survey_active;

    // predicted receiver state
    mode_t       mode_now;
    hunt_t       hunt;
    int unsigned count;
    logic [15:0] plen;
    logic [7:0]  cls;
    logic [7:0]  ident;
    logic [7:0]  tm_mode;
    logic [31:0] cap_w[5];
    logic [7:0]  cap_f[2];
    survey_t     kept;
    logic [31:0] min_secs;

    rx_result_t  pending_rx_results[$];

    int unsigned idle_pct     = 0;
    int unsigned stall_pct    = 0;
    int unsigned bytes_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned frames_seen  = 0;
    int unsigned fwd_seen     = 0;
    int unsigned survey_reqs  = 0;
    int unsigned fixed_reqs   = 0;
    int unsigned errors       = 0;

    ubx_survey_frame_receiver dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .forward_valid  (forward_valid),
        .frame_done     (frame_done),
        .base_mode      (base_mode),
        .config_request (config_request),
        .mean_x         (mean_x),
        .mean_y         (mean_y),
        .mean_z         (mean_z),
        .mean_accuracy  (mean_accuracy),
        .survey_seconds (survey_seconds),
        .survey_valid   (survey_valid),
        .survey_active  (survey_active)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t ns: mismatch on %s, got %h, want %h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin : check_results
        rx_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_rx_results.size() == 0)
            begin
                note_mismatch("result with nothing pending", 32'd1, 32'd0);
            end
            else
            begin
                want = pending_rx_results.pop_front();
                results_seen++;
                if (want.step.done)
                    frames_seen++;
                if (want.step.fwd)
                    fwd_seen++;
                if (want.step.req == REQ_SURVEY)
                    survey_reqs++;
                if (want.step.req == REQ_FIXED)
                    fixed_reqs++;
                if (forward_valid !== want.step.fwd)
                    note_mismatch("forward_valid", forward_valid, want.step.fwd);
                if (frame_done !== want.step.done)
                    note_mismatch("frame_done", frame_done, want.step.done);
                if (base_mode !== want.mode)
                    note_mismatch("base_mode", base_mode, want.mode);
                if (config_request !== want.step.req)
                    note_mismatch("config_request", config_request, want.step.req);
                if (mean_x !== want.svy.x)
                    note_mismatch("mean_x", mean_x, want.svy.x);
                if (mean_y !== want.svy.y)
                    note_mismatch("mean_y", mean_y, want.svy.y);
                if (mean_z !== want.svy.z)
                    note_mismatch("mean_z", mean_z, want.svy.z);
                if (mean_accuracy !== want.svy.accuracy)
                    note_mismatch("mean_accuracy", mean_accuracy, want.svy.accuracy);
                if (survey_seconds !== want.svy.duration)
                    note_mismatch("survey_seconds", survey_seconds, want.svy.duration);
                if (survey_valid !== want.svy.valid)
                    note_mismatch("survey_valid", survey_valid, want.svy.valid);
                if (survey_active !== want.svy.active)
                    note_mismatch("survey_active", survey_active, want.svy.active);
            end
        end
    end

    // advance the predicted parser by one accepted byte and queue what it should show
    task automatic predict_rx_result(input logic [7:0] b);
        rx_result_t  r;
        logic [15:0] total;
        int unsigned off;
        r.step.fwd  = 1'b0;
        r.step.done = 1'b0;
        r.step.req  = REQ_NONE;
        if (mode_now == MODE_FIXED)
        begin
            r.step.fwd = 1'b1;
        end
        else if (hunt == HUNT_SYNC_A)
        begin
            if (b == SYNC_A)
            begin
                count = 1;
                hunt  = HUNT_SYNC_B;
            end
        end
        else if (hunt == HUNT_SYNC_B)
        begin
            // a wrong second sync, a repeated first sync too, goes back to hunting
            if (b == SYNC_B)
            begin
                count = 2;
                hunt  = IN_FRAME;
            end
            else
            begin
                count = 0;
                hunt  = HUNT_SYNC_A;
            end
        end
        else
        begin
            off = count - 6;
            case (count)
                2: cls = b;
                3: ident = b;
                4: plen[7:0] = b;
                5: plen[15:8] = b;
                default:
                begin
                    if (off == 2)
                        tm_mode = b;
                    else if (off >= 8 && off < 24)
                        cap_w[(off - 8) >> 2][8 * (off % 4) +: 8] = b;
                    else if (off >= 28 && off < 32)
                        cap_w[4][8 * (off % 4) +: 8] = b;
                    else if (off == 36)
                        cap_f[0] = b;
                    else if (off == 37)
                        cap_f[1] = b;
                end
            endcase
            count++;
            total = plen + HDR_LEN;
            if (count >= 8 && count == total)
            begin
                r.step.done = 1'b1;
                hunt  = HUNT_SYNC_A;
                count = 0;
                if (plen >= MIN_PAYLOAD)
                begin
                    if (cls == CLS_CFG && ident == ID_TMODE3)
                    begin
                        if (tm_mode == TM3_SURVEY_IN)
                            mode_now = MODE_SURVEY;
                        else if (tm_mode == TM3_FIXED)
                            mode_now = MODE_FIXED;
                        else
                        begin
                            r.step.req = REQ_SURVEY;
                            mode_now   = MODE_SURVEY;
                        end
                    end
                    else if (cls == CLS_NAV && ident == ID_SVIN)
                    begin
                        kept.duration = cap_w[0];
                        kept.x        = cap_w[1];
                        kept.y        = cap_w[2];
                        kept.z        = cap_w[3];
                        kept.accuracy = cap_w[4];
                        kept.valid    = (cap_f[0] != 8'h00);
                        kept.active   = (cap_f[1] != 8'h00);
                        if (kept.valid && !kept.active && kept.duration >= min_secs)
                        begin
                            r.step.req = REQ_FIXED;
                            mode_now   = MODE_FIXED;
                        end
                    end
                end
            end
            else if (count >= FRAME_LIMIT)
            begin
                hunt  = HUNT_SYNC_A;
                count = 0;
            end
        end
        r.mode = mode_now;
        r.svy  = kept;
        pending_rx_results.push_back(r);
    endtask

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_rx_result(b);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [7:0] c, input logic [7:0] id,
                               input logic [15:0] len);
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(c);
        send_byte(id);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
    endtask

    task automatic send_frame(input logic [7:0] c, input logic [7:0] id, input byte_q_t body);
        send_header(c, id, 16'(body.size()));
        foreach (body[i])
            send_byte(body[i]);
        // checksum is not looked at, any value will do
        send_byte(8'($urandom));
        send_byte(8'($urandom));
    endtask

    // keep sending until the open frame completes or is dropped
    task automatic finish_frame(input bit zero_fill);
        while (hunt == IN_FRAME && mode_now != MODE_FIXED)
            send_byte(zero_fill ? 8'h00 : 8'($urandom));
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (pending_rx_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_min_duration(input logic [31:0] v);
        wait_results_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        min_secs = v;
    endtask

    task automatic set_idling(input int unsigned idle, input int unsigned stall);
        idle_pct  = idle;
        stall_pct = stall;
    endtask

    function automatic byte_q_t random_bytes(input int unsigned n);
        byte_q_t q;
        for (int i = 0; i < n; i++)
            q.push_back(8'($urandom));
        return q;
    endfunction

    function automatic byte_q_t svin_body(input int unsigned len, input logic [31:0] dur,
                                          input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] z, input logic [31:0] acc,
                                          input logic [7:0] fv, input logic [7:0] fa);
        byte_q_t q;
        q = random_bytes(len);
        for (int k = 0; k < 4; k++)
        begin
            q[8 + k]  = dur[8 * k +: 8];
            q[12 + k] = x[8 * k +: 8];
            q[16 + k] = y[8 * k +: 8];
            q[20 + k] = z[8 * k +: 8];
            q[28 + k] = acc[8 * k +: 8];
        end
        q[36] = fv;
        q[37] = fa;
        return q;
    endfunction

    function automatic byte_q_t random_svin_body(input int unsigned len);
        logic [31:0] dur;
        logic [7:0]  fv;
        logic [7:0]  fa;
        case ($urandom_range(3))
            0:       dur = $urandom_range(100);
            1:       dur = min_secs - 32'($urandom_range(2));
            default: dur = $urandom;
        endcase
        fv = $urandom_range(1) ? 8'($urandom_range(1, 255)) : 8'h00;
        fa = $urandom_range(1) ? 8'($urandom_range(1, 255)) : 8'h00;
        // stay out of fixed mode until the last part of the run
        if (fv != 8'h00 && fa == 8'h00 && dur >= min_secs)
            fa = 8'($urandom_range(1, 255));
        return svin_body(len, dur, $urandom, $urandom, $urandom, $urandom, fv, fa);
    endfunction

    function automatic byte_q_t random_tmode3_body(input int unsigned len);
        byte_q_t q;
        q = random_bytes(len);
        case ($urandom_range(2))
            0:       q[2] = TM3_SURVEY_IN;
            1:       q[2] = 8'h00;
            default: if (q[2] == TM3_FIXED) q[2] = 8'h03;
        endcase
        return q;
    endfunction

    task automatic test_sync_hunting();
        byte_q_t none;
        send_byte(8'h00);
        send_byte(SYNC_B);
        // a repeated first sync does not restart framing
        send_byte(SYNC_A);
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(SYNC_A);
        send_byte(8'h00);
        send_byte(8'hFF);
        // empty payload still closes a frame
        send_frame(CLS_NAV, ID_SVIN, none);
    endtask

    task automatic test_short_and_foreign_frames();
        send_frame(CLS_CFG, ID_TMODE3, random_bytes(39));
        send_frame(CLS_NAV, ID_SVIN, random_bytes(39));
        send_frame(CLS_NAV, ID_TMODE3, random_svin_body(40));
        send_frame(CLS_CFG, ID_SVIN, random_bytes(40));
    endtask

    task automatic test_tmode3_replies();
        byte_q_t body;
        body = random_bytes(40);
        body[2] = TM3_SURVEY_IN;
        send_frame(CLS_CFG, ID_TMODE3, body);
        body[2] = 8'h00;
        send_frame(CLS_CFG, ID_TMODE3, body);
        body = random_bytes(48);
        body[2] = 8'hFF;
        send_frame(CLS_CFG, ID_TMODE3, body);
    endtask

    task automatic test_survey_extremes();
        send_frame(CLS_NAV, ID_SVIN, svin_body(40, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                               32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'h01));
        send_frame(CLS_NAV, ID_SVIN, svin_body(40, '0, '0, '0, '0, '0, 8'h00, 8'h00));
        // valid and finished, but one second short of the minimum
        send_frame(CLS_NAV, ID_SVIN, svin_body(41, min_secs - 1, $urandom, $urandom, $urandom,
                                               $urandom, 8'h01, 8'h00));
        send_frame(CLS_NAV, ID_SVIN, svin_body(40, 32'hFFFF_FFFF, '1, '1, '1, '1, 8'h00, 8'h00));
    endtask

    task automatic test_frame_limit();
        // total length exactly at the limit completes rather than being dropped
        send_header(CLS_CFG, ID_TMODE3, 16'(FRAME_LIMIT - HDR_LEN));
        finish_frame(1'b1);
    endtask

    task automatic test_random_traffic(input int unsigned n_bytes);
        int unsigned stop_at;
        int unsigned len;
        int unsigned cut;
        byte_q_t     body;
        logic [7:0]  c;
        logic [7:0]  id;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at && mode_now != MODE_FIXED)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(40, 56);
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6:
                    send_frame(CLS_NAV, ID_SVIN, random_svin_body(len));
                7, 8, 9, 10:
                    send_frame(CLS_CFG, ID_TMODE3, random_tmode3_body(len));
                11:
                begin
                    if ($urandom_range(1))
                        send_frame(CLS_NAV, ID_SVIN, random_bytes($urandom_range(39)));
                    else
                        send_frame(CLS_CFG, ID_TMODE3, random_bytes($urandom_range(39)));
                end
                12, 13:
                begin
                    c  = 8'($urandom);
                    id = 8'($urandom);
                    if ((c == CLS_CFG && id == ID_TMODE3) || (c == CLS_NAV && id == ID_SVIN))
                        id = id ^ 8'h80;
                    send_frame(c, id, random_bytes($urandom_range(64)));
                end
                14, 15, 16:
                begin
                    repeat ($urandom_range(1, 6))
                        send_byte(($urandom_range(3) == 0) ? SYNC_A : 8'($urandom));
                end
                default:
                begin
                    // header promises more than is sent, zeros close the frame out
                    cut = $urandom_range(34);
                    if ($urandom_range(1))
                    begin
                        body = random_svin_body(len);
                        send_header(CLS_NAV, ID_SVIN, 16'(len));
                    end
                    else
                    begin
                        body = random_tmode3_body(len);
                        send_header(CLS_CFG, ID_TMODE3, 16'(len));
                    end
                    for (int i = 0; i < cut; i++)
                        send_byte(body[i]);
                    finish_frame(1'b1);
                end
            endcase
        end
    endtask

    task automatic test_switch_to_fixed();
        logic [31:0] limit_secs;
        byte_q_t     body;
        limit_secs = $urandom_range(21, 32'h7FFF_FFFF);
        set_idling(0, 0);
        // close out whatever the random traffic left half framed
        finish_frame(1'b1);
        if (hunt == HUNT_SYNC_B && mode_now != MODE_FIXED)
            send_byte(8'h00);
        write_min_duration(limit_secs);
        send_frame(CLS_NAV, ID_SVIN, svin_body(40, limit_secs - 1, $urandom, $urandom,
                                               $urandom, $urandom, 8'h01, 8'h00));
        send_frame(CLS_NAV, ID_SVIN, svin_body(44, limit_secs, $urandom, $urandom,
                                               $urandom, $urandom, 8'h01, 8'h01));
        if ($urandom_range(1))
        begin
            send_frame(CLS_NAV, ID_SVIN, svin_body(40, limit_secs, $urandom, $urandom,
                                                   $urandom, $urandom, 8'h80, 8'h00));
        end
        else
        begin
            body = random_bytes(40);
            body[2] = TM3_FIXED;
            send_frame(CLS_CFG, ID_TMODE3, body);
        end
        // from here on every byte is forwarded, sync bytes included
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       set_idling(0, 0);
                1:       set_idling(76, 0);
                2:       set_idling(0, 76);
                default: set_idling(28, 28);
            endcase
            send_header(CLS_CFG, ID_TMODE3, 16'd40);
            repeat (8)
                send_byte(8'($urandom));
        end
    endtask

    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        mode_now = MODE_IDLE;
        hunt     = HUNT_SYNC_A;
        count    = 0;
        plen     = '0;
        cls      = '0;
        ident    = '0;
        tm_mode  = '0;
        foreach (cap_w[i])
            cap_w[i] = '0;
        cap_f[0] = '0;
        cap_f[1] = '0;
        kept     = '0;
        min_secs = SURVEY_MIN_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(0, 0);
        test_sync_hunting();
        test_short_and_foreign_frames();
        set_idling(76, 0);
        test_tmode3_replies();
        set_idling(0, 76);
        test_survey_extremes();
        set_idling(28, 28);
        test_frame_limit();

        write_min_duration(32'hFFFF_FFFF);
        set_idling(0, 0);
        test_random_traffic(30);
        write_min_duration(32'h0000_0000);
        set_idling(76, 0);
        test_random_traffic(30);
        write_min_duration($urandom);
        set_idling(0, 76);
        test_random_traffic(30);
        write_min_duration($urandom_range(1000));
        set_idling(28, 28);
        test_random_traffic(30);

        test_switch_to_fixed();

        in_valid <= 1'b0;
        for (int n = 0; n < 10000 && pending_rx_results.size() != 0; n++)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (pending_rx_results.size() != 0)
            note_mismatch("results never returned", pending_rx_results.size(), 32'd0);

        $display("checked %0d byte results: %0d frames closed, %0d survey-in, %0d fixed requests",
                 results_seen, frames_seen, survey_reqs, fixed_reqs);
        $display("%0d bytes forwarded as corrections, final mode %s, survey minimum %0d s",
                 fwd_seen, mode_now.name(), min_secs);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
